FILE: rtl/mcvt_pkg.sv
// Shared types and constants for the matrix compose / vertex transform unit.
// No dependencies; used by mcvt_lane and matrix_compose_and_vertex_transform.
`timescale 1ns / 1ps
`default_nettype none

package mcvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    // four shifted products summed exactly
    localparam int ACC_W     = SHIFT_W + 2;

    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_COMPOSE   = 2'd1,
        ACT_IDENTITY  = 2'd2,
        ACT_TRANSFORM = 2'd3
    } t_action;

    // issue control for one lane, one product per cycle
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: rtl/mcvt_lane.sv
// One dot-product lane: registered 32x32 multiply, floor shift, accumulate,
// saturate. Depends on mcvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcvt_lane (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mcvt_pkg::t_lane_ctl i_ctl,
    input  mcvt_pkg::t_data     i_a,
    input  mcvt_pkg::t_data     i_b,
    output logic                o_done,
    output mcvt_pkg::t_data     o_res,
    output logic                o_sat
);

    mcvt_pkg::t_lane_ctl                      r_pctl;
    logic signed [mcvt_pkg::PROD_W-1:0]       r_prod;
    logic signed [mcvt_pkg::ACC_W-1:0]        r_acc;
    logic                                     r_done;

    logic signed [mcvt_pkg::PROD_W-1:0]       n_prod;
    logic signed [mcvt_pkg::SHIFT_W-1:0]      w_shift;
    logic signed [mcvt_pkg::ACC_W-1:0]        n_acc;
    logic [mcvt_pkg::ACC_W-mcvt_pkg::DATA_W:0] w_hi;

    assign n_prod  = i_a * i_b;
    // arithmetic shift = floor rounding of the product
    assign w_shift = $signed(r_prod[mcvt_pkg::PROD_W-1:mcvt_pkg::FRAC_BITS]);
    assign n_acc   = r_pctl.first ? mcvt_pkg::ACC_W'(w_shift)
                                  : r_acc + mcvt_pkg::ACC_W'(w_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
        end
        r_prod <= n_prod;
        if (r_pctl.valid) begin
            r_acc <= n_acc;
        end
    end

    // in range only if all bits from 31 up agree
    assign w_hi   = r_acc[mcvt_pkg::ACC_W-1:mcvt_pkg::DATA_W-1];
    assign o_sat  = !((&w_hi) || (~|w_hi));
    assign o_res  = o_sat ? (r_acc[mcvt_pkg::ACC_W-1] ? mcvt_pkg::FX_MIN : mcvt_pkg::FX_MAX)
                          : r_acc[mcvt_pkg::DATA_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/matrix_compose_and_vertex_transform.sv
// Top level: current/staging matrices, command sequencer, four mcvt_lane
// instances and the merge of their results. Depends on mcvt_pkg, mcvt_lane.
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------------------------------------------
//   command   | start / busy       | i_action, i_element_index, i_element_value,
//             |                    | i_vec_x, i_vec_y, i_vec_z, i_vec_w
//   result    | o_valid (strobe)   | o_out_x, o_out_y, o_out_z, o_out_w,
//             |                    | o_saturated
//
// A transaction is taken when start is high and busy low. Write and identity
// finish in the accept cycle, busy stays low. A transform keeps busy high through
// the issue state (one product per lane per cycle through the lane multiplier)
// and the drain state, while the lane product and accumulator registers empty;
// o_valid pulses in the last busy cycle. A compose issues 4 rows x 4 terms, then drains.
// Reset (synchronous) loads identity into current and zeros into staging.
// The receiver cannot stall; each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module matrix_compose_and_vertex_transform (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          i_action,
    input  wire  [3:0]          i_element_index,
    input  wire  signed [31:0]  i_element_value,
    input  wire  signed [31:0]  i_vec_x,
    input  wire  signed [31:0]  i_vec_y,
    input  wire  signed [31:0]  i_vec_z,
    input  wire  signed [31:0]  i_vec_w,
    output logic                o_valid,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic                o_saturated
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state              r_state;
    mcvt_pkg::t_action   r_op;
    logic [1:0]          r_k;
    logic [1:0]          r_row;
    logic [1:0]          r_wrow;
    mcvt_pkg::t_data     r_cur [16];
    mcvt_pkg::t_data     r_stg [16];
    mcvt_pkg::t_data     r_buf [3][4];
    mcvt_pkg::t_data     r_vec [4];

    mcvt_pkg::t_lane_ctl w_ctl;
    mcvt_pkg::t_data     w_a   [4];
    mcvt_pkg::t_data     w_b   [4];
    mcvt_pkg::t_data     w_res [4];
    logic [3:0]          w_done;
    logic [3:0]          w_sat;
    logic                w_accept;
    logic                w_is_tf;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_is_tf  = (r_op == mcvt_pkg::ACT_TRANSFORM);

    assign w_ctl.valid = (r_state == S_ISSUE);
    assign w_ctl.first = (r_k == 2'd0);
    assign w_ctl.last  = (r_k == 2'd3);

    for (genvar i = 0; i < 4; i++) begin : g_lane
        // transform: lane i = row i dot v; compose: lane i = column i of result row
        assign w_a[i] = w_is_tf ? r_vec[r_k] : r_stg[{r_row, r_k}];
        assign w_b[i] = w_is_tf ? r_cur[{2'(i), r_k}] : r_cur[{r_k, 2'(i)}];

        mcvt_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_a     (w_a[i]),
            .i_b     (w_b[i]),
            .o_done  (w_done[i]),
            .o_res   (w_res[i]),
            .o_sat   (w_sat[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= mcvt_pkg::ACT_WRITE;
            r_k     <= 2'd0;
            r_row   <= 2'd0;
            r_wrow  <= 2'd0;
            for (int i = 0; i < 16; i++) begin
                r_cur[i] <= (i % 5 == 0) ? mcvt_pkg::FX_ONE : '0;
                r_stg[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_k    <= 2'd0;
                        r_row  <= 2'd0;
                        r_wrow <= 2'd0;
                        case (mcvt_pkg::t_action'(i_action))
                            mcvt_pkg::ACT_WRITE: begin
                                r_stg[i_element_index] <= i_element_value;
                            end
                            mcvt_pkg::ACT_IDENTITY: begin
                                for (int i = 0; i < 16; i++) begin
                                    r_cur[i] <= (i % 5 == 0) ? mcvt_pkg::FX_ONE : '0;
                                end
                            end
                            mcvt_pkg::ACT_COMPOSE: begin
                                r_op    <= mcvt_pkg::ACT_COMPOSE;
                                r_state <= S_ISSUE;
                            end
                            default: begin
                                r_op    <= mcvt_pkg::ACT_TRANSFORM;
                                r_state <= S_ISSUE;
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_row <= r_row + 2'd1;
                        if (w_is_tf || r_row == 2'd3) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_done[0] && (w_is_tf || r_wrow == 2'd3)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // compose rows come back one at a time; old current must
            // stay intact until the last row is in
            if (w_done[0] && !w_is_tf) begin
                r_wrow <= r_wrow + 2'd1;
                if (r_wrow == 2'd3) begin
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            r_cur[r*4 + c] <= r_buf[r][c];
                        end
                    end
                    for (int c = 0; c < 4; c++) begin
                        r_cur[12 + c] <= w_res[c];
                    end
                end
            end
        end

        if (w_done[0] && !w_is_tf && r_wrow != 2'd3) begin
            for (int c = 0; c < 4; c++) begin
                r_buf[r_wrow][c] <= w_res[c];
            end
        end

        if (w_accept) begin
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_vec[3] <= i_vec_w;
        end
    end

    // combinational merge of the lane results
    assign o_valid     = w_done[0] && w_is_tf;
    assign o_out_x     = w_res[0];
    assign o_out_y     = w_res[1];
    assign o_out_z     = w_res[2];
    assign o_out_w     = w_res[3];
    assign o_saturated = |w_sat;

endmodule

`default_nettype wire
